// ----- design/cvrs_pkg.sv -----
// Shared types and constants for the compressed aircraft record parser.
// No dependencies; imported by the interfaces, the parser and the top level.
`default_nettype none
package cvrs_pkg;

   localparam int BYTE_W         = 8;
   localparam int ID_W           = 24;
   localparam int MASK_W         = 9;
   localparam int CALLSIGN_W     = 64;
   localparam int CALLSIGN_MAX   = CALLSIGN_W / BYTE_W;
   localparam int ALT_W          = 24;
   localparam int WORD16_W       = 16;
   localparam int WORD32_W       = 32;
   localparam int CODE_W         = 2;

   localparam logic [7:0] MIN_RECORD_LEN = 8'd10;
   localparam logic [7:0] GROUND_BIT     = 8'h08;

   localparam logic [CODE_W-1:0] STATUS_SAME    = 2'd0;
   localparam logic [CODE_W-1:0] STATUS_NEW     = 2'd1;
   localparam logic [CODE_W-1:0] STATUS_SHORT   = 2'd2;
   localparam logic [CODE_W-1:0] STATUS_OVERRUN = 2'd3;

   localparam logic [CODE_W-1:0] GSTATE_UNKNOWN  = 2'd0;
   localparam logic [CODE_W-1:0] GSTATE_AIRBORNE = 2'd1;
   localparam logic [CODE_W-1:0] GSTATE_GROUND   = 2'd2;

   localparam int NUM_ITEMS = 9;
   localparam logic [3:0] ITEM_CALLSIGN = 4'd0;
   localparam logic [3:0] ITEM_ALT      = 4'd1;
   localparam logic [3:0] ITEM_SPD      = 4'd2;
   localparam logic [3:0] ITEM_TRK      = 4'd3;
   localparam logic [3:0] ITEM_LAT      = 4'd4;
   localparam logic [3:0] ITEM_LON      = 4'd5;
   localparam logic [3:0] ITEM_VSI      = 4'd6;
   localparam logic [3:0] ITEM_SQK      = 4'd7;
   localparam logic [3:0] ITEM_FLAG     = 4'd8;

   localparam logic [2:0] ITEM_SIZE [NUM_ITEMS] =
      '{3'd1, 3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd2, 3'd2, 3'd1};

   typedef struct packed {
      logic [ID_W-1:0]              aircraft_id;
      logic [MASK_W-1:0]            present_mask;
      logic [CALLSIGN_W-1:0]        callsign_text;
      logic signed [ALT_W-1:0]      altitude_feet;
      logic signed [WORD16_W-1:0]   ground_speed;
      logic signed [WORD16_W-1:0]   track_tenths;
      logic [WORD32_W-1:0]          latitude_bits;
      logic [WORD32_W-1:0]          longitude_bits;
      logic signed [WORD16_W-1:0]   vertical_rate;
      logic [WORD16_W-1:0]          squawk_code;
      logic [CODE_W-1:0]            ground_state;
      logic [CODE_W-1:0]            record_status;
   } result_type;

endpackage
`default_nettype wire

// ----- design/cvrs_req_if.sv -----
// Input channel: one stream byte per word with valid/ready handshake.
// Depends on cvrs_pkg.
`default_nettype none
interface cvrs_req_if;
   import cvrs_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- design/cvrs_rsp_if.sv -----
// Result channel: one decoded record per word with valid/ready handshake.
// Depends on cvrs_pkg.
`default_nettype none
interface cvrs_rsp_if;
   import cvrs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ID_W-1:0]            aircraft_id;
   logic [MASK_W-1:0]          present_mask;
   logic [CALLSIGN_W-1:0]      callsign_text;
   logic signed [ALT_W-1:0]    altitude_feet;
   logic signed [WORD16_W-1:0] ground_speed;
   logic signed [WORD16_W-1:0] track_tenths;
   logic [WORD32_W-1:0]        latitude_bits;
   logic [WORD32_W-1:0]        longitude_bits;
   logic signed [WORD16_W-1:0] vertical_rate;
   logic [WORD16_W-1:0]        squawk_code;
   logic [CODE_W-1:0]          ground_state;
   logic [CODE_W-1:0]          record_status;

   modport source (output valid, output aircraft_id, output present_mask,
                   output callsign_text, output altitude_feet, output ground_speed,
                   output track_tenths, output latitude_bits, output longitude_bits,
                   output vertical_rate, output squawk_code, output ground_state,
                   output record_status, input ready);
   modport sink   (input valid, input aircraft_id, input present_mask,
                   input callsign_text, input altitude_feet, input ground_speed,
                   input track_tenths, input latitude_bits, input longitude_bits,
                   input vertical_rate, input squawk_code, input ground_state,
                   input record_status, output ready);
endinterface
`default_nettype wire

// ----- design/compressed_vrs_record_parser_unit.sv -----
// A result enters the result register or the skid entry as its last byte is accepted.
// Throughput: one byte per cycle; a result register plus one skid entry let
// bytes keep flowing while a finished record waits on the result channel.
// Input stalls only when both the result register and the skid entry are full.
// Reset (synchronous, active high) returns to the length byte of a new record,
// forgets the last aircraft and drops any undelivered result.
`default_nettype none
module compressed_vrs_record_parser_unit #(
   parameter int CALLSIGN_BYTES = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cvrs_req_if.sink   req_chan,
   cvrs_rsp_if.source rsp_chan
);
   import cvrs_pkg::*;

   logic       accept;
   logic       drain;
   logic       emit;
   result_type result;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   result_type skid_data_ff, skid_data_in;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && !skid_valid_ff;
   assign drain          = rsp_valid_ff && rsp_chan.ready;

   cvrs_parser #(
      .CALLSIGN_BYTES (CALLSIGN_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .emit      (emit),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (drain) begin
         rsp_valid_in = 1'b0;
      end
      if (skid_valid_ff && (!rsp_valid_ff || drain)) begin
         rsp_data_in   = skid_data_ff;
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end
      if (emit) begin
         if (!rsp_valid_ff || drain) begin
            rsp_data_in  = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.aircraft_id    = rsp_data_ff.aircraft_id;
   assign rsp_chan.present_mask   = rsp_data_ff.present_mask;
   assign rsp_chan.callsign_text  = rsp_data_ff.callsign_text;
   assign rsp_chan.altitude_feet  = rsp_data_ff.altitude_feet;
   assign rsp_chan.ground_speed   = rsp_data_ff.ground_speed;
   assign rsp_chan.track_tenths   = rsp_data_ff.track_tenths;
   assign rsp_chan.latitude_bits  = rsp_data_ff.latitude_bits;
   assign rsp_chan.longitude_bits = rsp_data_ff.longitude_bits;
   assign rsp_chan.vertical_rate  = rsp_data_ff.vertical_rate;
   assign rsp_chan.squawk_code    = rsp_data_ff.squawk_code;
   assign rsp_chan.ground_state   = rsp_data_ff.ground_state;
   assign rsp_chan.record_status  = rsp_data_ff.record_status;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a word ahead of the result register");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_chan.ready))
      else $error("skid entry filled while result register was free");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> !skid_valid_ff)
      else $error("record finished with no room to hold its word");

endmodule
`default_nettype wire

// ----- design/cvrs_parser.sv -----
// Byte-wise record parser: position counter, phase machine and result assembly.
// Depends on cvrs_pkg; gives the finished record in the cycle of its last byte.
`default_nettype none
module cvrs_parser #(
   parameter int CALLSIGN_BYTES = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   output logic                      emit,
   output cvrs_pkg::result_type      result
);
   import cvrs_pkg::*;

   localparam int CS_CW = $clog2(CALLSIGN_BYTES + 1);

   typedef enum logic [11:0] {
      PH_HEAD  = 12'b0000_0000_0001,
      PH_CSLEN = 12'b0000_0000_0010,
      PH_CSCHR = 12'b0000_0000_0100,
      PH_ALT   = 12'b0000_0000_1000,
      PH_SPD   = 12'b0000_0001_0000,
      PH_TRK   = 12'b0000_0010_0000,
      PH_LAT   = 12'b0000_0100_0000,
      PH_LON   = 12'b0000_1000_0000,
      PH_VSI   = 12'b0001_0000_0000,
      PH_SQK   = 12'b0010_0000_0000,
      PH_FLAG  = 12'b0100_0000_0000,
      PH_TAIL  = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] left;
      logic       overrun;
   } adv_type;

   function automatic phase_type item_phase(input logic [3:0] item);
      phase_type p;
      unique case (item)
         ITEM_CALLSIGN: p = PH_CSLEN;
         ITEM_ALT:      p = PH_ALT;
         ITEM_SPD:      p = PH_SPD;
         ITEM_TRK:      p = PH_TRK;
         ITEM_LAT:      p = PH_LAT;
         ITEM_LON:      p = PH_LON;
         ITEM_VSI:      p = PH_VSI;
         ITEM_SQK:      p = PH_SQK;
         ITEM_FLAG:     p = PH_FLAG;
         default:       p = PH_TAIL;
      endcase
      return p;
   endfunction

   // pick the next present item at or after first; nextpos is the next byte index
   function automatic adv_type advance(input logic [3:0] first, input logic [8:0] nextpos,
                                       input logic [7:0] fmask, input logic [7:0] gmask,
                                       input logic [7:0] len);
      adv_type    a;
      logic       found;
      logic       present;
      logic [9:0] end_pos;
      a.phase   = PH_TAIL;
      a.left    = 8'd0;
      a.overrun = 1'b0;
      found     = 1'b0;
      for (int k = 0; k < NUM_ITEMS; k++) begin
         present = (4'(k) == ITEM_FLAG) ? (gmask != 8'd0) : fmask[3'(k)];
         end_pos = {1'b0, nextpos} + 10'(ITEM_SIZE[k]);
         if (!found && 4'(k) >= first && present) begin
            found = 1'b1;
            if (end_pos > {2'b00, len}) begin
               a.overrun = 1'b1;
            end else begin
               a.phase = item_phase(4'(k));
               a.left  = 8'(ITEM_SIZE[k]);
            end
         end
      end
      return a;
   endfunction

   phase_type          phase_ff, phase_in;
   logic [7:0]         pos_ff, pos_in;
   logic [7:0]         len_ff, len_in;
   logic [7:0]         fmask_ff, fmask_in;
   logic [7:0]         gmask_ff, gmask_in;
   logic [7:0]         left_ff, left_in;
   logic [31:0]        gather_ff, gather_in;
   logic [CS_CW-1:0]   cs_count_ff, cs_count_in;
   logic [ID_W-1:0]    last_id_ff, last_id_in;
   logic               last_valid_ff, last_valid_in;
   result_type         res_ff, res_in;

   logic [8:0]         pos_p1;
   logic [9:0]         cs_end;
   logic               do_adv;
   logic [3:0]         adv_first;
   adv_type            adv;

   assign pos_p1 = {1'b0, pos_ff} + 9'd1;
   assign cs_end = {1'b0, pos_p1} + {2'b00, data_byte};

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      fmask_in      = fmask_ff;
      gmask_in      = gmask_ff;
      left_in       = left_ff;
      gather_in     = gather_ff;
      cs_count_in   = cs_count_ff;
      last_id_in    = last_id_ff;
      last_valid_in = last_valid_ff;
      res_in        = res_ff;
      do_adv        = 1'b0;
      adv_first     = ITEM_CALLSIGN;
      emit          = 1'b0;

      unique case (phase_ff) inside
         PH_HEAD: begin
            if (pos_ff == 8'd0) begin
               res_in      = '0;
               gather_in   = '0;
               cs_count_in = '0;
               fmask_in    = '0;
               gmask_in    = '0;
               left_in     = '0;
               len_in      = data_byte;
               if (data_byte < MIN_RECORD_LEN) begin
                  res_in.record_status = STATUS_SHORT;
                  phase_in             = PH_TAIL;
               end
            end else if (pos_ff >= 8'd4 && pos_ff <= 8'd6) begin
               gather_in = {8'd0, gather_ff[15:0], data_byte};
               if (pos_ff == 8'd6) begin
                  res_in.aircraft_id   = gather_in[ID_W-1:0];
                  res_in.record_status = (!last_valid_ff || last_id_ff != gather_in[ID_W-1:0])
                                         ? STATUS_NEW : STATUS_SAME;
                  last_id_in           = gather_in[ID_W-1:0];
                  last_valid_in        = 1'b1;
               end
            end else if (pos_ff == 8'd7) begin
               fmask_in                 = data_byte;
               res_in.present_mask[7:0] = data_byte;
            end else if (pos_ff == 8'd8) begin
               gmask_in  = data_byte;
               do_adv    = 1'b1;
               adv_first = ITEM_CALLSIGN;
            end
         end
         PH_CSLEN: begin
            if (data_byte == 8'd0) begin
               do_adv    = 1'b1;
               adv_first = ITEM_ALT;
            end else if (cs_end > {2'b00, len_ff}) begin
               res_in.record_status = STATUS_OVERRUN;
               phase_in             = PH_TAIL;
            end else begin
               left_in     = data_byte;
               cs_count_in = '0;
               phase_in    = PH_CSCHR;
            end
         end
         PH_CSCHR: begin
            for (int i = 0; i < CALLSIGN_MAX; i++) begin
               if (i < CALLSIGN_BYTES && cs_count_ff == CS_CW'(i)) begin
                  res_in.callsign_text[8*i +: 8] = data_byte;
               end
            end
            if (cs_count_ff < CS_CW'(CALLSIGN_BYTES)) begin
               cs_count_in = cs_count_ff + CS_CW'(1);
            end
            left_in = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               do_adv    = 1'b1;
               adv_first = ITEM_ALT;
            end
         end
         PH_ALT, PH_SPD, PH_TRK, PH_LAT, PH_LON, PH_VSI, PH_SQK: begin
            gather_in = (phase_ff == PH_ALT) ? {gather_ff[23:0], data_byte}
                                             : {data_byte, gather_ff[31:8]};
            left_in   = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               do_adv = 1'b1;
               unique case (phase_ff)
                  PH_ALT: begin
                     res_in.altitude_feet = gather_in[23]
                        ? ALT_W'(24'd0 - {1'b0, gather_in[22:0]}) : gather_in[23:0];
                     adv_first = ITEM_SPD;
                  end
                  PH_SPD: begin
                     res_in.ground_speed = gather_in[31:16];
                     adv_first           = ITEM_TRK;
                  end
                  PH_TRK: begin
                     res_in.track_tenths = gather_in[31:16];
                     adv_first           = ITEM_LAT;
                  end
                  PH_LAT: begin
                     res_in.latitude_bits = gather_in;
                     adv_first            = ITEM_LON;
                  end
                  PH_LON: begin
                     res_in.longitude_bits = gather_in;
                     adv_first             = ITEM_VSI;
                  end
                  PH_VSI: begin
                     res_in.vertical_rate = gather_in[31:16];
                     adv_first            = ITEM_SQK;
                  end
                  default: begin
                     res_in.squawk_code = gather_in[31:16];
                     adv_first          = ITEM_FLAG;
                  end
               endcase
            end
         end
         PH_FLAG: begin
            if ((gmask_ff & GROUND_BIT) != 8'd0) begin
               res_in.present_mask[8] = 1'b1;
               res_in.ground_state    = ((data_byte & GROUND_BIT) != 8'd0)
                                        ? GSTATE_GROUND : GSTATE_AIRBORNE;
            end
            phase_in = PH_TAIL;
         end
         PH_TAIL: begin
         end
         default: begin
            phase_in = PH_TAIL;
         end
      endcase

      adv = advance(adv_first, pos_p1, fmask_in, gmask_in, len_in);
      if (do_adv) begin
         if (adv.overrun) begin
            res_in.record_status = STATUS_OVERRUN;
            phase_in             = PH_TAIL;
         end else begin
            phase_in  = adv.phase;
            left_in   = adv.left;
            gather_in = '0;
         end
      end

      if (pos_p1 >= {1'b0, len_in}) begin
         emit     = accept;
         pos_in   = 8'd0;
         phase_in = PH_HEAD;
      end else begin
         pos_in = pos_p1[7:0];
      end
   end

   assign result = res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD;
         pos_ff        <= '0;
         len_ff        <= '0;
         fmask_ff      <= '0;
         gmask_ff      <= '0;
         left_ff       <= '0;
         gather_ff     <= '0;
         cs_count_ff   <= '0;
         last_id_ff    <= '0;
         last_valid_ff <= 1'b0;
         res_ff        <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         fmask_ff      <= fmask_in;
         gmask_ff      <= gmask_in;
         left_ff       <= left_in;
         gather_ff     <= gather_in;
         cs_count_ff   <= cs_count_in;
         last_id_ff    <= last_id_in;
         last_valid_ff <= last_valid_in;
         res_ff        <= res_in;
      end
   end

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      emit |=> (pos_ff == 8'd0 && phase_ff == PH_HEAD))
      else $error("record end did not restart header parsing");

   a_overrun_tail: assert property (@(posedge clock) disable iff (reset)
      (res_ff.record_status == STATUS_OVERRUN) |->
         (phase_ff == PH_TAIL || (phase_ff == PH_HEAD && pos_ff == 8'd0)))
      else $error("overrun record still decoding fields");

   a_field_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CSCHR || phase_ff == PH_ALT || phase_ff == PH_SPD ||
       phase_ff == PH_TRK || phase_ff == PH_LAT || phase_ff == PH_LON ||
       phase_ff == PH_VSI || phase_ff == PH_SQK) |-> (left_ff != 8'd0))
      else $error("field phase with no bytes left");

endmodule
`default_nettype wire

// ----- verif/record_decode_checker.sv -----
// Watches the byte and record channels of the record parser, predicts each
// decoded record from the accepted bytes and compares it field by field.
// Depends on cvrs_pkg, cvrs_req_if and cvrs_rsp_if.
`default_nettype none
module record_decode_checker #(
   parameter int CALLSIGN_KEEP = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   cvrs_req_if       byte_bus,
   cvrs_rsp_if       record_bus,
   output int        mismatches,
   output int        records_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import cvrs_pkg::*;

   localparam int ID_FIRST_AT = 4;
   localparam int ID_LAST_AT  = 6;
   localparam int MASK_AT     = 7;
   localparam int FLAGS_AT    = 8;

   typedef enum int {
      ST_HEADER   = 0,
      ST_CS_COUNT = 1,
      ST_CS_CHARS = 2,
      ST_ALT      = 3,
      ST_SPEED    = 4,
      ST_TRACK    = 5,
      ST_LAT      = 6,
      ST_LON      = 7,
      ST_VRATE    = 8,
      ST_SQUAWK   = 9,
      ST_FLAG     = 10,
      ST_TAIL     = 11
   } parse_stage_type;

   parse_stage_type stage;
   int           at_byte;
   int           rec_len;
   int           bytes_to_go;
   logic [7:0]   field_sel;
   logic [7:0]   flag_sel;
   logic [31:0]  accum;
   logic [63:0]  call_accum;
   result_type   draft;
   logic [23:0]  prev_id;
   bit           prev_id_seen;
   result_type   expected_records[$];
   result_type   want;

   // pick the next present field at or after 'first'; flag the record if it will not fit
   function automatic void select_field(input int first, input int next_at);
      bit present;
      for (int i = first; i < NUM_ITEMS; i++) begin
         present = (i < int'(ITEM_FLAG)) ? field_sel[i] : (flag_sel != 8'h00);
         if (present) begin
            if (next_at + int'(ITEM_SIZE[i]) > rec_len) begin
               draft.record_status = STATUS_OVERRUN;
               stage = ST_TAIL;
            end else begin
               stage = (i == ITEM_CALLSIGN) ? ST_CS_COUNT :
                       parse_stage_type'(int'(ST_ALT) + i - int'(ITEM_ALT));
               bytes_to_go = ITEM_SIZE[i];
               accum = '0;
            end
            return;
         end
      end
      stage = ST_TAIL;
   endfunction

   function automatic void store_value(input int item);
      logic [23:0] mag;
      case (item)
         ITEM_ALT: begin
            mag = accum[23:0];
            if (mag[23])
               mag = 24'd0 - {1'b0, mag[22:0]};
            draft.altitude_feet = mag;
         end
         ITEM_SPD: draft.ground_speed   = accum[15:0];
         ITEM_TRK: draft.track_tenths   = accum[15:0];
         ITEM_LAT: draft.latitude_bits  = accum;
         ITEM_LON: draft.longitude_bits = accum;
         ITEM_VSI: draft.vertical_rate  = accum[15:0];
         ITEM_SQK: draft.squawk_code    = accum[15:0];
         default: ;
      endcase
   endfunction

   task automatic decode_byte(input logic [7:0] b);
      int item;
      int idx;
      case (stage)
         ST_HEADER: begin
            if (at_byte == 0) begin
               draft = '0;
               call_accum = '0;
               accum = '0;
               field_sel = '0;
               flag_sel = '0;
               bytes_to_go = 0;
               rec_len = b;
               if (b < MIN_RECORD_LEN) begin
                  draft.record_status = STATUS_SHORT;
                  stage = ST_TAIL;
               end
            end else if (at_byte >= ID_FIRST_AT && at_byte <= ID_LAST_AT) begin
               accum = {8'h00, accum[15:0], b};
               if (at_byte == ID_LAST_AT) begin
                  draft.aircraft_id = accum[23:0];
                  draft.record_status = (!prev_id_seen || prev_id != accum[23:0]) ?
                                        STATUS_NEW : STATUS_SAME;
                  prev_id = accum[23:0];
                  prev_id_seen = 1'b1;
               end
            end else if (at_byte == MASK_AT) begin
               field_sel = b;
               draft.present_mask[7:0] = b;
            end else if (at_byte == FLAGS_AT) begin
               flag_sel = b;
               select_field(ITEM_CALLSIGN, at_byte + 1);
            end
         end
         ST_CS_COUNT: begin
            if (b == 8'h00) begin
               select_field(ITEM_ALT, at_byte + 1);
            end else if (at_byte + 1 + int'(b) > rec_len) begin
               draft.record_status = STATUS_OVERRUN;
               stage = ST_TAIL;
            end else begin
               bytes_to_go = b;
               accum = '0;
               stage = ST_CS_CHARS;
            end
         end
         ST_CS_CHARS: begin
            if (accum < CALLSIGN_KEEP)
               call_accum |= 64'(b) << (8 * accum);
            accum++;
            bytes_to_go--;
            if (bytes_to_go == 0)
               select_field(ITEM_ALT, at_byte + 1);
         end
         ST_FLAG: begin
            if ((flag_sel & GROUND_BIT) != 8'h00) begin
               draft.present_mask[8] = 1'b1;
               draft.ground_state = ((b & GROUND_BIT) != 8'h00) ? GSTATE_GROUND :
                                                                 GSTATE_AIRBORNE;
            end
            select_field(NUM_ITEMS, at_byte + 1);
         end
         ST_TAIL: ;
         default: begin
            item = int'(stage) - int'(ST_ALT) + int'(ITEM_ALT);
            if (item == ITEM_ALT) begin
               accum = {accum[23:0], b};
            end else begin
               idx = int'(ITEM_SIZE[item]) - bytes_to_go;
               if (idx < 4)
                  accum |= 32'(b) << (8 * idx);
            end
            bytes_to_go--;
            if (bytes_to_go == 0) begin
               store_value(item);
               select_field(item + 1, at_byte + 1);
            end
         end
      endcase
      at_byte++;
      if (at_byte >= rec_len) begin
         draft.callsign_text = call_accum;
         expected_records.push_back(draft);
         at_byte = 0;
         stage = ST_HEADER;
      end
   endtask

   function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                         input logic [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stage = ST_HEADER;
         at_byte = 0;
         rec_len = 0;
         bytes_to_go = 0;
         field_sel = '0;
         flag_sel = '0;
         accum = '0;
         call_accum = '0;
         draft = '0;
         prev_id = '0;
         prev_id_seen = 1'b0;
         mismatches = 0;
         expected_records.delete();
      end else begin
         if (record_bus.valid && record_bus.ready) begin
            if (expected_records.size() == 0) begin
               $error("record word with none pending: aircraft_id %0h",
                      record_bus.aircraft_id);
               mismatches++;
            end else begin
               want = expected_records.pop_front();
               compare_field("aircraft_id", want.aircraft_id, record_bus.aircraft_id);
               compare_field("present_mask", want.present_mask, record_bus.present_mask);
               compare_field("callsign_text", want.callsign_text, record_bus.callsign_text);
               compare_field("altitude_feet", want.altitude_feet, record_bus.altitude_feet);
               compare_field("ground_speed", want.ground_speed, record_bus.ground_speed);
               compare_field("track_tenths", want.track_tenths, record_bus.track_tenths);
               compare_field("latitude_bits", want.latitude_bits, record_bus.latitude_bits);
               compare_field("longitude_bits", want.longitude_bits,
                             record_bus.longitude_bits);
               compare_field("vertical_rate", want.vertical_rate, record_bus.vertical_rate);
               compare_field("squawk_code", want.squawk_code, record_bus.squawk_code);
               compare_field("ground_state", want.ground_state, record_bus.ground_state);
               compare_field("record_status", want.record_status, record_bus.record_status);
            end
         end
         if (byte_bus.valid && byte_bus.ready)
            decode_byte(byte_bus.data_byte);
      end
      records_due <= expected_records.size();
   end
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Top level of the record parser test: clock, reset, byte stream stimulus
// with directed and random records, receiver stalls and the final verdict.
// Depends on cvrs_pkg, the channel interfaces, the parser and record_decode_checker.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cvrs_pkg::*;

   localparam int CALLSIGN_KEEP = 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 10;
   localparam int PHASE_BYTES   = 30;
   localparam int PHASE_RECORDS = 3;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_SIGN_HI,
      FILL_SIGN_LO,
      FILL_MAX_HI,
      FILL_MAX_LO
   } fill_mode_type;

   logic       clock;
   logic       reset;
   int         mismatch_count;
   int         records_due;
   int         send_idle_pct;
   int         stall_pct;
   logic       hold_active;
   int         idle_cycles;
   int         bytes_sent;
   logic [23:0] last_sent_id;
   logic [7:0] record_body[$];
   event       hold_go;

   cvrs_req_if req_chan ();
   cvrs_rsp_if rsp_chan ();

   compressed_vrs_record_parser_unit #(
      .CALLSIGN_BYTES(CALLSIGN_KEEP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   record_decode_checker #(
      .CALLSIGN_KEEP(CALLSIGN_KEEP)
   ) decode_check (
      .clock(clock),
      .reset(reset),
      .byte_bus(req_chan),
      .record_bus(rsp_chan),
      .mismatches(mismatch_count),
      .records_due(records_due)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
   end

   initial begin
      hold_active = 1'b0;
      forever begin
         @(hold_go);
         @(posedge clock);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] fill_byte(input fill_mode_type mode, input int i, input int n);
      case (mode)
         FILL_ZERO:    return 8'h00;
         FILL_ONES:    return 8'hff;
         FILL_SIGN_HI: return (i == 0) ? 8'h80 : 8'h00;
         FILL_SIGN_LO: return (i == n - 1) ? 8'h80 : 8'h00;
         FILL_MAX_HI:  return (i == 0) ? 8'h7f : 8'hff;
         FILL_MAX_LO:  return (i == n - 1) ? 8'h7f : 8'hff;
         default:      return 8'($urandom);
      endcase
   endfunction

   // record without its length byte, fields in mask order
   function automatic void build_body(input logic [23:0] id, input logic [7:0] fmask,
                                      input logic [7:0] flmask, input int cs_len,
                                      input logic [7:0] flag_byte, input fill_mode_type mode);
      record_body.delete();
      repeat (3) record_body.push_back(8'($urandom));
      record_body.push_back(id[23:16]);
      record_body.push_back(id[15:8]);
      record_body.push_back(id[7:0]);
      record_body.push_back(fmask);
      record_body.push_back(flmask);
      if (fmask[ITEM_CALLSIGN]) begin
         record_body.push_back(8'(cs_len));
         for (int i = 0; i < cs_len; i++)
            record_body.push_back(fill_byte(mode, i, cs_len));
      end
      for (int k = ITEM_ALT; k <= ITEM_SQK; k++) begin
         if (fmask[k]) begin
            for (int i = 0; i < ITEM_SIZE[k]; i++)
               record_body.push_back(fill_byte(mode, i, ITEM_SIZE[k]));
         end
      end
      if (flmask != 8'h00)
         record_body.push_back(flag_byte);
      last_sent_id = id;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // slack > 0 pads with trailing bytes, slack < 0 truncates the record
   task automatic send_record(input int slack);
      int len;
      len = record_body.size() + 1 + slack;
      if (len < 0) len = 0;
      if (len > 255) len = 255;
      send_byte(8'(len));
      for (int i = 1; i < len; i++)
         send_byte((i <= record_body.size()) ? record_body[i - 1] : 8'($urandom));
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (records_due != 0) @(posedge clock);
   endtask

   task automatic send_random_record();
      int          pick;
      logic [23:0] id;
      logic [7:0]  fmask;
      logic [7:0]  flmask;
      int          cs_len;
      fill_mode_type mode;
      pick = $urandom_range(99);
      if (pick >= 85) begin
         record_body.delete();
         if (pick >= 97)
            send_record(int'($urandom_range(255)) - 1);
         else
            send_record(int'($urandom_range(9)) - 1);
         return;
      end
      case ($urandom_range(2))
         0:       id = last_sent_id;
         1:       id = 24'h4a0000 + 24'($urandom_range(3));
         default: id = 24'($urandom);
      endcase
      fmask = 8'($urandom);
      case ($urandom_range(3))
         0:       flmask = 8'h00;
         1:       flmask = GROUND_BIT | 8'($urandom);
         2:       flmask = 8'($urandom) & ~GROUND_BIT;
         default: flmask = 8'($urandom);
      endcase
      cs_len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(10);
      mode = ($urandom_range(9) == 0) ? fill_mode_type'($urandom_range(int'(FILL_MAX_LO))) :
                                        FILL_RANDOM;
      build_body(id, fmask, flmask, cs_len, 8'($urandom), mode);
      if (pick < 70)
         send_record(($urandom_range(2) == 0) ? int'($urandom_range(4, 1)) : 0);
      else
         send_record(-int'($urandom_range(6, 1)));
   endtask

   initial begin
      int phase_start;
      int phase_records;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      reset = 1'b1;
      send_idle_pct = 0;
      stall_pct = 0;
      bytes_sent = 0;
      last_sent_id = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      build_body(24'h000000, 8'h00, 8'h00, 0, 8'h00, FILL_RANDOM);
      send_record(1);
      build_body(24'h000000, 8'h00, 8'h00, 0, 8'h00, FILL_RANDOM);
      send_record(1);
      build_body(24'hffffff, 8'hff, 8'hff, 8, 8'hff, FILL_ONES);
      send_record(0);
      build_body(24'hffffff, 8'hff, GROUND_BIT, 8, 8'h00, FILL_ZERO);
      send_record(0);
      build_body(24'h800001, 8'hfe, 8'h00, 0, 8'h00, FILL_SIGN_HI);
      send_record(0);
      build_body(24'h800001, 8'hfe, GROUND_BIT, 0, GROUND_BIT, FILL_SIGN_LO);
      send_record(0);
      build_body(24'h7ffffe, 8'hff, 8'h01, 3, 8'hff, FILL_MAX_HI);
      send_record(0);
      build_body(24'h7ffffe, 8'hfe, 8'h01, 0, 8'h00, FILL_MAX_LO);
      send_record(0);
      build_body(24'h123456, 8'h81, 8'h00, 12, 8'h00, FILL_RANDOM);
      send_record(0);
      build_body(24'h123456, 8'h03, 8'h00, 0, 8'h00, FILL_RANDOM);
      send_record(0);
      build_body(24'h123456, 8'h00, 8'hf7, 0, 8'hff, FILL_RANDOM);
      send_record(0);
      build_body(24'h123456, 8'h10, 8'h00, 0, 8'h00, FILL_RANDOM);
      send_record(3);
      record_body.delete();
      send_record(-1);
      send_record(0);
      send_record(8);
      build_body(24'h654321, 8'h01, 8'h00, 5, 8'h00, FILL_RANDOM);
      send_record(-5);
      build_body(24'h654321, 8'h02, 8'h00, 0, 8'h00, FILL_RANDOM);
      send_record(-2);
      build_body(24'h654321, 8'h04, GROUND_BIT, 0, GROUND_BIT, FILL_RANDOM);
      send_record(-1);
      build_body(24'h0a0b0c, 8'hff, GROUND_BIT, 4, 8'h00, FILL_RANDOM);
      send_record(-7);
      build_body(24'hc0ffee, 8'hff, GROUND_BIT, 8, 8'h00, FILL_RANDOM);
      send_record(255 - record_body.size() - 1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 53; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 53; end
            default: begin send_idle_pct = 37; stall_pct <= 37; end
         endcase
         phase_start = bytes_sent;
         phase_records = 0;
         // stall the result side while the byte stream keeps coming
         if (phase == 0)
            -> hold_go;
         while (bytes_sent - phase_start < PHASE_BYTES || phase_records < PHASE_RECORDS) begin
            send_random_record();
            phase_records++;
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// ----- compressed_vrs_record_parser_unit.f -----
design/cvrs_pkg.sv
design/cvrs_req_if.sv
design/cvrs_rsp_if.sv
design/cvrs_parser.sv
design/compressed_vrs_record_parser_unit.sv
verif/record_decode_checker.sv
verif/testbench.sv
